// ===== rtl/apq_pkg.sv =====
// Shared types and codes for the array priority queue.
// Used by apq_ram consumers, apq_ctrl, apq_dpath and the top level.
package apq_pkg;

	localparam int PRI_W = 16;
	localparam int PAY_W = 32;

	// result status codes
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// request opcodes
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} opcode_t;

	// one stored entry, priority in the low bits
	typedef struct packed {
		logic signed [PAY_W-1:0] pay;
		logic signed [PRI_W-1:0] pri;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic    cap;
		logic    ins;
		logic    st_load;
		status_t st_code;
		logic    scan_init;
		logic    scan_rd;
		logic    shift_init;
		logic    shift_rd;
		logic    pop;
		logic    out_ld;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_remove;
		logic full;
		logic empty;
		logic scan_last;
		logic shift_done;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/apq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/apq_ctrl.sv =====
// Sequencer for the array priority queue: accept, decide, scan, shift, finish.
// Depends on apq_pkg; drives apq_dpath through cmd_t, reads sts_t.
module apq_ctrl import apq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_DRAIN,
		S_SH_INIT,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		cmd.st_code = ST_INSERTED;
		in_ready = 1'b0;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.op_remove) begin
					cmd.st_load = 1'b1;
					if (sts.full) begin
						cmd.st_code = ST_FULL;
					end else begin
						cmd.ins     = 1'b1;
						cmd.st_code = ST_INSERTED;
					end
					state_d = S_FINISH;
				end else if (sts.empty) begin
					cmd.st_load = 1'b1;
					cmd.st_code = ST_EMPTY;
					state_d     = S_FINISH;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			// last read word is compared here
			S_DRAIN: begin
				state_d = S_SH_INIT;
			end
			S_SH_INIT: begin
				cmd.shift_init = 1'b1;
				state_d        = S_SHIFT;
			end
			S_SHIFT: begin
				if (sts.shift_done) begin
					cmd.pop     = 1'b1;
					cmd.st_load = 1'b1;
					cmd.st_code = ST_REMOVED;
					state_d     = S_FINISH;
				end else begin
					cmd.shift_rd = 1'b1;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/apq_dpath.sv =====
// Datapath for the array priority queue: ring pointers, entry RAM,
// max-priority scan, gap-closing shift and output register.
// Depends on apq_pkg and apq_ram; controlled by apq_ctrl.
module apq_dpath import apq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              in_opcode,
	input  entry_t            in_entry,
	output logic              out_valid,
	input  logic              out_ready,
	output status_t           out_status,
	output entry_t            out_entry
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);

	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [OW-1:0] occ_q;
	logic [AW-1:0] k_q;

	opcode_t       req_op_q;
	entry_t        req_entry_q;

	logic          rd_vld_s1;
	logic [AW-1:0] rd_k_s1;
	logic          sh_vld_s1;
	logic [AW-1:0] sh_dst_s1;

	logic [AW-1:0]           best_k_q;
	entry_t                  best_q;
	status_t                 res_st_q;
	entry_t                  res_q;

	logic          out_valid_q;
	status_t       out_status_q;
	entry_t        out_entry_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;

	// ring index at offset k from the head, k up to DEPTH
	function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] head,
		input logic [AW:0] k);
		logic [AW:0] sum;
		sum = {1'b0, head} + k;
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign ram_raddr = cmd.shift_rd ? ring_at(head_q, {1'b0, k_q - 1'b1})
	                                : ring_at(head_q, {1'b0, k_q});
	assign ram_we    = cmd.ins | sh_vld_s1;
	assign ram_waddr = cmd.ins ? tail_q : sh_dst_s1;
	assign ram_wdata = cmd.ins ? req_entry_q : ram_rdata;

	apq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			k_q         <= '0;
			rd_vld_s1   <= 1'b0;
			sh_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			sh_vld_s1 <= cmd.shift_rd;
			if (cmd.ins) begin
				tail_q <= ring_next(tail_q);
				occ_q  <= occ_q + 1'b1;
			end
			if (cmd.pop) begin
				head_q <= ring_next(head_q);
				occ_q  <= occ_q - 1'b1;
			end
			if (cmd.scan_init) begin
				k_q <= '0;
			end else if (cmd.scan_rd) begin
				k_q <= k_q + 1'b1;
			end else if (cmd.shift_init) begin
				k_q <= best_k_q;
			end else if (cmd.shift_rd) begin
				k_q <= k_q - 1'b1;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_op_q    <= opcode_t'(in_opcode);
			req_entry_q <= in_entry;
		end
		rd_k_s1   <= k_q;
		sh_dst_s1 <= ring_at(head_q, {1'b0, k_q});
		// first word seeds the max; ties keep the earlier one
		if (rd_vld_s1 && ((rd_k_s1 == '0) || (ram_rdata.pri > best_q.pri))) begin
			best_q   <= ram_rdata;
			best_k_q <= rd_k_s1;
		end
		if (cmd.st_load) begin
			res_st_q <= cmd.st_code;
			res_q    <= cmd.pop ? best_q : '0;
		end
		if (cmd.out_ld) begin
			out_status_q <= res_st_q;
			out_entry_q  <= res_q;
		end
	end

	assign sts.op_remove  = (req_op_q == OP_REMOVE);
	assign sts.full       = (occ_q == OW'(DEPTH));
	assign sts.empty      = (occ_q == '0);
	assign sts.scan_last  = (({1'b0, k_q} + 1'b1) == (AW+1)'(occ_q));
	assign sts.shift_done = (k_q == '0);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_entry  = out_entry_q;

`ifndef ASSERT_OFF
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(DEPTH))
		else $error("occupancy above depth");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		ring_at(head_q, (AW+1)'(occ_q)) == tail_q)
		else $error("head, tail and occupancy disagree");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && sh_vld_s1))
		else $error("insert write collides with shift write");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending one");
`endif

endmodule

// ===== rtl/array_priority_queue_unit.sv =====
// Array priority queue: top level joining apq_ctrl and apq_dpath.
// Depends on apq_pkg, apq_ctrl, apq_dpath (and apq_ram below it).
//
// Bounded priority queue of DEPTH entries kept in one RAM in arrival order.
// Each request gives exactly one result. A remove of n stored entries whose
// winner sits at offset b from the head does one RAM read per cycle to
// scan all n priorities, then one read/write per cycle to move the b older
// entries one slot toward the tail; the single RAM read port is why the scan
// and the shift run one after the other and not side by side.
// One request is worked at a time; a new request is
// taken while the previous result still sits in the output register.
module array_priority_queue_unit import apq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [15:0] priority_req, [47:16] payload
	input  logic [0:0]  s_axis_tuser,   // [0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [15:0] out_priority, [47:16] out_payload
	output logic [1:0]  m_axis_tuser    // [1:0] status
);

	cmd_t    cmd;
	sts_t    sts;
	entry_t  in_entry;
	entry_t  out_entry;
	status_t out_status;

	assign in_entry.pri = s_axis_tdata[PRI_W-1:0];
	assign in_entry.pay = s_axis_tdata[PRI_W+PAY_W-1:PRI_W];

	apq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	apq_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_opcode (s_axis_tuser[0]),
		.in_entry  (in_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_status(out_status),
		.out_entry (out_entry)
	);

	assign m_axis_tdata = {out_entry.pay, out_entry.pri};
	assign m_axis_tuser = out_status;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for array_priority_queue_unit: request stream in, result stream out.
// Keeps its own model of the queue and checks every result in order.
// Depends on apq_pkg and the array_priority_queue_unit RTL.
`timescale 1ns / 100ps

module tb_top;
	import apq_pkg::*;

	localparam int DEPTH = 16;

	typedef struct {
		status_t                 st;
		logic signed [PRI_W-1:0] pri;
		logic signed [PAY_W-1:0] pay;
	} queue_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // [15:0] priority_req, [47:16] payload
	logic [0:0]  s_axis_tuser;   // [0] opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // [15:0] out_priority, [47:16] out_payload
	logic [1:0]  m_axis_tuser;   // [1:0] status

	entry_t        stored_entries[$];    // model contents, oldest first
	queue_result_t awaited_results[$];
	int            error_count = 0;
	int            tx_gap_pct = 0;
	int            rx_stall_pct = 0;
	int            rx_hold_request = 0;

	array_priority_queue_unit #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("** array_priority_queue_unit: FAILED **");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic queue_result_t predict_request(opcode_t op,
			logic signed [PRI_W-1:0] pri, logic signed [PAY_W-1:0] pay);
		queue_result_t r;
		entry_t        e;
		int            win;
		r.pri = '0;
		r.pay = '0;
		if (op == OP_INSERT) begin
			if (stored_entries.size() >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				e.pri = pri;
				e.pay = pay;
				stored_entries.push_back(e);
				r.st = ST_INSERTED;
			end
		end else if (stored_entries.size() == 0) begin
			r.st = ST_EMPTY;
		end else begin
			// strict compare keeps the oldest entry on a tie
			win = 0;
			for (int k = 1; k < stored_entries.size(); k++)
				if ($signed(stored_entries[k].pri) > $signed(stored_entries[win].pri))
					win = k;
			r.st  = ST_REMOVED;
			r.pri = stored_entries[win].pri;
			r.pay = stored_entries[win].pay;
			stored_entries.delete(win);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < 50)
			$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic send_request(input opcode_t op, input logic signed [PRI_W-1:0] pri,
			input logic signed [PAY_W-1:0] pay);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pay, pri};
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		awaited_results.push_back(predict_request(op, pri, pay));
		if ($urandom_range(0, 99) < tx_gap_pct) begin
			gap = pick_gap();
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	task automatic check_result();
		queue_result_t           want;
		logic [1:0]              got_st;
		logic signed [PRI_W-1:0] got_pri;
		logic signed [PAY_W-1:0] got_pay;
		got_st  = m_axis_tuser;
		got_pri = m_axis_tdata[15:0];
		got_pay = m_axis_tdata[47:16];
		if (awaited_results.size() == 0) begin
			report_mismatch($sformatf("result with no request pending, status %0d", got_st));
			return;
		end
		want = awaited_results.pop_front();
		if (got_st !== want.st)
			report_mismatch($sformatf("status %0d, want %0d", got_st, want.st));
		if (got_pri !== want.pri)
			report_mismatch($sformatf("priority %0d, want %0d", got_pri, want.pri));
		if (got_pay !== want.pay)
			report_mismatch($sformatf("payload %0h, want %0h", got_pay, want.pay));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result();
	end

	// result side: random stalls plus an occasional long hold-off
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_request > 0) begin
				hold_left = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < rx_stall_pct) begin
				stall_left = pick_gap() - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// empty remove, extreme fields, ties, fill to full, refused insert, removes
	task automatic test_directed();
		logic signed [PRI_W-1:0] fill_pri[16] = '{
			16'sd100, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd5, 16'sd5,
			16'sh8000, -16'sd2, 16'sd7, 16'sd7, 16'sd1, -16'sd100, 16'sd200, 16'sd3};
		logic signed [PAY_W-1:0] fill_pay[16] = '{
			32'sd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd2, 32'sd0, -32'sd1,
			32'sh5555_5555, 32'shaaaa_aaaa, 32'sd3, 32'sd4, 32'sd5, 32'sd6, 32'sd7,
			32'sd8, 32'sd9, 32'sd10};
		send_request(OP_REMOVE, 16'sd0, 32'sd0);
		for (int k = 0; k < 16; k++)
			send_request(OP_INSERT, fill_pri[k], fill_pay[k]);
		send_request(OP_INSERT, 16'sd1234, 32'sh1234_5678);
		repeat (5) send_request(OP_REMOVE, 16'sh7fff, -32'sd1);
	endtask

	task automatic test_random_traffic(input int n_items);
		int                      insert_bias;
		int                      r;
		opcode_t                 op;
		logic signed [PRI_W-1:0] pri;
		logic signed [PAY_W-1:0] pay;
		insert_bias = 50;
		for (int n = 0; n < n_items; n++) begin
			// swing occupancy between empty and full in runs
			if (n % 40 == 0) begin
				r = $urandom_range(0, 2);
				insert_bias = (r == 0) ? 15 : (r == 1) ? 55 : 85;
			end
			op = ($urandom_range(0, 99) < insert_bias) ? OP_INSERT : OP_REMOVE;
			r = $urandom_range(0, 9);
			if (r < 5)
				pri = 16'(int'($urandom_range(0, 6)) - 3);   // dense range, many ties
			else if (r < 8)
				pri = 16'($urandom);
			else if (r == 8)
				pri = 16'sh7fff;
			else
				pri = 16'sh8000;
			pay = $urandom;
			send_request(op, pri, pay);
			if ($urandom_range(0, 99) < 2)
				wait_all_results();
		end
	endtask

	// result side held off while requests keep coming, so the input backs up
	task automatic test_output_backpressure();
		tx_gap_pct = 0;
		rx_hold_request = 300;
		for (int n = 0; n < 48; n++)
			send_request((n % 3 == 2) ? OP_REMOVE : OP_INSERT, 16'($urandom), $urandom);
		wait_all_results();
	endtask

	task automatic test_sender_pause();
		tx_gap_pct = 20;
		rx_stall_pct = 20;
		for (int n = 0; n < 20; n++)
			send_request((n % 2 == 0) ? OP_INSERT : OP_REMOVE, 16'($urandom), $urandom);
		wait_all_results();
		for (int n = 0; n < 20; n++)
			send_request((n % 4 == 3) ? OP_REMOVE : OP_INSERT, 16'($urandom), $urandom);
		wait_all_results();
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_INSERT;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		tx_gap_pct = 30;
		rx_stall_pct = 25;
		test_random_traffic(700);
		test_output_backpressure();
		test_sender_pause();
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		test_random_traffic(300);
		tx_gap_pct = 60;
		rx_stall_pct = 50;
		test_random_traffic(650);

		wait_all_results();
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("** array_priority_queue_unit: PASSED **");
		else
			$display("** array_priority_queue_unit: FAILED **");
		$finish;
	end

endmodule
